// File: hw/rtl/bilinear_texture_sampler_top_assert.svh
// assertion macros for the bilinear texture sampler top level
`ifndef BILINEAR_TEXTURE_SAMPLER_TOP_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bts assertion failed");
// next-cycle implication
`define BTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bts assertion failed");
`else
`define BTS_ASSERT_NOW(label, ante, cons)
`define BTS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/bts_pkg.sv
// shared types, constants and helpers of the bilinear texture sampler
package bts_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int DIM_W    = 9;
  localparam int COORD_W  = 17;
  localparam int IDX_W    = 16;
  localparam int CH_W     = 8;
  localparam int TEXEL_W  = 3 * CH_W;
  localparam int FRAC_W   = 16;
  localparam int ONE_Q16  = 1 << FRAC_W;
  localparam int PX_W     = COORD_W + DIM_W;
  localparam int XR_W     = PX_W - FRAC_W;
  localparam int ROW_W    = 2 * DIM_W;
  localparam int S_W      = 8;
  localparam int S_ONE    = 1 << S_W;
  localparam int WGT_W    = 2 * S_W + 1;
  localparam int WPROD_W  = 2 * S_W + 2;
  localparam int TPROD_W  = WGT_W + CH_W;
  localparam int ACC_W    = TPROD_W + 1;
  localparam int ROUND    = 1 << (FRAC_W - 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0]     DIM_RESET  = 9'd256;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_SAMPLE   = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [IDX_W-1:0]   texel_index;
    logic [CH_W-1:0]    load_red;
    logic [CH_W-1:0]    load_green;
    logic [CH_W-1:0]    load_blue;
    logic [COORD_W-1:0] coord_u;
    logic [COORD_W-1:0] coord_v;
  } in_req_t;

  typedef struct packed {
    logic [CH_W-1:0] sample_red;
    logic [CH_W-1:0] sample_green;
    logic [CH_W-1:0] sample_blue;
    logic            status;
  } out_req_t;

  // request leaving the coordinate stages toward the texel store
  typedef struct packed {
    logic                        valid;
    logic                        load;
    logic                        load_ok;
    logic                        err;
    logic [ADDR_W-1:0]           waddr;
    logic [TEXEL_W-1:0]          wdata;
    logic [3:0][ADDR_W-1:0]      raddr;
    logic [3:0][WGT_W-1:0]       wgt;
  } bts_iss_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] val,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] res;
    if (val == '0) begin
      res = DIM_W'(1);
    end else if (32'(val) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = val;
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/bts_ram.sv
// generic ram, one write port and two registered read ports
module bts_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: hw/rtl/bts_coord.sv
// coordinate scaling, edge clamp, store addresses and bilinear weights
module bts_coord import bts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_req_t          in_req,
  input  logic [DIM_W-1:0] tex_w,
  input  logic [DIM_W-1:0] tex_h,
  input  logic             iss_rdy,
  output bts_iss_t         iss
);

  // stage 1: scaled coordinates
  logic               v1_r;
  logic               load1_r;
  logic               ldok1_r;
  logic               err1_r;
  logic [ADDR_W-1:0]  idx1_r;
  logic [TEXEL_W-1:0] col1_r;
  logic [PX_W-1:0]    px1_r;
  logic [PX_W-1:0]    py1_r;

  // stage 2: clamped texel positions and fractions
  logic               v2_r;
  logic               load2_r;
  logic               ldok2_r;
  logic               err2_r;
  logic [ADDR_W-1:0]  idx2_r;
  logic [TEXEL_W-1:0] col2_r;
  logic [DIM_W-1:0]   x0_r, x1_r, y0_r, y1_r;
  logic [S_W-1:0]     s_r, t_r;

  logic rdy1, rdy2, accept;

  assign rdy2     = !v2_r || iss_rdy;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      load1_r <= (in_req.command == CMD_LOAD);
      ldok1_r <= ((IDX_W + 1)'(in_req.texel_index) < (IDX_W + 1)'(STORE_DEPTH));
      err1_r  <= (in_req.coord_u > COORD_W'(ONE_Q16)) ||
                 (in_req.coord_v > COORD_W'(ONE_Q16));
      idx1_r  <= ADDR_W'(in_req.texel_index);
      col1_r  <= {in_req.load_red, in_req.load_green, in_req.load_blue};
      px1_r   <= PX_W'(in_req.coord_u) * PX_W'(tex_w);
      py1_r   <= PX_W'(in_req.coord_v) * PX_W'(tex_h);
    end
  end

  // clamp integer parts and their right or lower neighbor to the last texel
  logic [XR_W-1:0] wm1, hm1, x0_raw, y0_raw, x0c, y0c, x0_inc, y0_inc, x1c, y1c;

  always_comb begin
    wm1    = XR_W'(tex_w - DIM_W'(1));
    hm1    = XR_W'(tex_h - DIM_W'(1));
    x0_raw = px1_r[PX_W-1:FRAC_W];
    y0_raw = py1_r[PX_W-1:FRAC_W];
    x0c    = (x0_raw > wm1) ? wm1 : x0_raw;
    y0c    = (y0_raw > hm1) ? hm1 : y0_raw;
    x0_inc = x0c + XR_W'(1);
    y0_inc = y0c + XR_W'(1);
    x1c    = (x0_inc > wm1) ? wm1 : x0_inc;
    y1c    = (y0_inc > hm1) ? hm1 : y0_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      load2_r <= load1_r;
      ldok2_r <= ldok1_r;
      err2_r  <= err1_r;
      idx2_r  <= idx1_r;
      col2_r  <= col1_r;
      x0_r    <= DIM_W'(x0c);
      x1_r    <= DIM_W'(x1c);
      y0_r    <= DIM_W'(y0c);
      y1_r    <= DIM_W'(y1c);
      s_r     <= px1_r[FRAC_W-1 -: S_W];
      t_r     <= py1_r[FRAC_W-1 -: S_W];
    end
  end

  // linear addresses and weights for the store read
  logic [ROW_W-1:0]   row0, row1;
  logic [S_W:0]       ns, nt;
  logic [WPROD_W-1:0] wa, wb, wc, wd;

  always_comb begin
    row0 = ROW_W'(tex_w) * ROW_W'(y0_r);
    row1 = ROW_W'(tex_w) * ROW_W'(y1_r);
    ns   = (S_W + 1)'(S_ONE) - (S_W + 1)'(s_r);
    nt   = (S_W + 1)'(S_ONE) - (S_W + 1)'(t_r);
    wa   = WPROD_W'(ns) * WPROD_W'(nt);
    wb   = WPROD_W'(s_r) * WPROD_W'(nt);
    wc   = WPROD_W'(ns) * WPROD_W'(t_r);
    wd   = WPROD_W'(s_r) * WPROD_W'(t_r);

    iss.valid    = v2_r;
    iss.load     = load2_r;
    iss.load_ok  = ldok2_r;
    iss.err      = err2_r;
    iss.waddr    = idx2_r;
    iss.wdata    = col2_r;
    iss.raddr[0] = ADDR_W'(row0 + ROW_W'(x0_r));
    iss.raddr[1] = ADDR_W'(row0 + ROW_W'(x1_r));
    iss.raddr[2] = ADDR_W'(row1 + ROW_W'(x0_r));
    iss.raddr[3] = ADDR_W'(row1 + ROW_W'(x1_r));
    iss.wgt[0]   = WGT_W'(wa);
    iss.wgt[1]   = WGT_W'(wb);
    iss.wgt[2]   = WGT_W'(wc);
    iss.wgt[3]   = WGT_W'(wd);
  end

endmodule

// File: hw/rtl/bts_blend.sv
// weighted sum of four texels per channel with rounding, and the output register
module bts_blend import bts_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_v,
  input  logic                     in_err,
  input  logic [3:0][WGT_W-1:0]    in_wgt,
  input  logic [3:0][TEXEL_W-1:0]  in_tex,
  output logic                     in_rdy,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_req_t                 out_req
);

  logic                         v4_r;
  logic                         err4_r;
  logic [2:0][3:0][TPROD_W-1:0] prod4_r;
  logic                         out_valid_r;
  out_req_t                     out_req_r;
  logic                         rdy_o;

  assign rdy_o  = !out_valid_r || !out_stall;
  assign in_rdy = !v4_r || rdy_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (in_rdy) begin
      v4_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      err4_r <= in_err;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod4_r[c][k] <= TPROD_W'(in_wgt[k]) *
                           TPROD_W'(in_tex[k][CH_W*(2-c) +: CH_W]);
        end
      end
    end
  end

  logic [2:0][ACC_W-1:0] acc;
  logic [2:0][CH_W-1:0]  chan;
  out_req_t              out_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(prod4_r[c][0]) + ACC_W'(prod4_r[c][1]) +
               ACC_W'(prod4_r[c][2]) + ACC_W'(prod4_r[c][3]) + ACC_W'(ROUND);
      chan[c] = err4_r ? '0 : acc[c][FRAC_W +: CH_W];
    end
    out_nxt.sample_red   = chan[0];
    out_nxt.sample_green = chan[1];
    out_nxt.sample_blue  = chan[2];
    out_nxt.status       = err4_r ? STATUS_RANGE : STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_o) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_req_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

// File: hw/rtl/bilinear_texture_sampler_top.sv
// top level of the bilinear texture sampler
//
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_req_t: load or sample request
// out_      output     out_valid / out_stall  out_req_t: filtered rgb and status
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data: texture size
//
// one request per cycle while in_stall is low, loads and samples alike; a
// sample passes stage 1, stage 2, the read stage, the blend product register
// and the output register, whose valid drives out_valid
// the rate is set by the two texel store copies: each gives two reads a cycle,
// so the four neighbors of a sample are fetched in the same cycle
// reset clears the pipeline valids and sets width and height to 256; the store
// has no clearing pass and holds no meaning until written
// out_stall only holds back the stages behind a waiting result; empty stages
// further up still fill, so in_stall rises only when the whole pipe is full
`include "bilinear_texture_sampler_top_assert.svh"
module bilinear_texture_sampler_top import bts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_req_t             out_req,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  // configuration registers, raw as written
  logic [DIM_W-1:0] tex_w_r;
  logic [DIM_W-1:0] tex_h_r;
  logic [DIM_W-1:0] tex_w;
  logic [DIM_W-1:0] tex_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= DIM_RESET;
      tex_h_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  tex_w_r <= cfg_data;
        REG_HEIGHT: tex_h_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // effective size, held to 1..max
  assign tex_w = clamp_dim(tex_w_r, MAX_WIDTH);
  assign tex_h = clamp_dim(tex_h_r, MAX_HEIGHT);

  // coordinate stages: scale, clamp, address and weight generation
  bts_iss_t iss;
  logic     iss_rdy;

  bts_coord u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .tex_w    (tex_w),
    .tex_h    (tex_h),
    .iss_rdy  (iss_rdy),
    .iss      (iss)
  );

  // texel store, kept as two identical copies so one request gets four reads;
  // loads write both copies in the same stage where samples read, so requests
  // touch the store strictly in accept order and no forwarding is needed
  logic                    v3_r;
  logic                    err3_r;
  logic [3:0][WGT_W-1:0]   wgt3_r;
  logic [3:0][TEXEL_W-1:0] tex;
  logic                    blend_rdy;
  logic                    st_we;

  assign iss_rdy = !v3_r || blend_rdy;
  assign st_we   = iss.valid && iss.load && iss.load_ok && iss_rdy;

  bts_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (ADDR_W),
    .DW    (TEXEL_W)
  ) u_store_top (
    .clk     (clk),
    .we      (st_we),
    .waddr   (iss.waddr),
    .wdata   (iss.wdata),
    .re      (iss_rdy),
    .raddr_a (iss.raddr[0]),
    .raddr_b (iss.raddr[1]),
    .rdata_a (tex[0]),
    .rdata_b (tex[1])
  );

  bts_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (ADDR_W),
    .DW    (TEXEL_W)
  ) u_store_bot (
    .clk     (clk),
    .we      (st_we),
    .waddr   (iss.waddr),
    .wdata   (iss.wdata),
    .re      (iss_rdy),
    .raddr_a (iss.raddr[2]),
    .raddr_b (iss.raddr[3]),
    .rdata_a (tex[2]),
    .rdata_b (tex[3])
  );

  // read stage: loads end here, samples go on with their weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (iss_rdy) begin
      v3_r <= iss.valid && !iss.load;
    end
  end

  always_ff @(posedge clk) begin
    if (iss_rdy) begin
      err3_r <= iss.err;
      wgt3_r <= iss.wgt;
    end
  end

  // blend and output register
  bts_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (v3_r),
    .in_err    (err3_r),
    .in_wgt    (wgt3_r),
    .in_tex    (tex),
    .in_rdy    (blend_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  // a sample moving into the read stage must show up there
  `BTS_ASSERT_NEXT(a_sample_reaches_read, iss_rdy && iss.valid && !iss.load, v3_r)
  // store read data of an in-range sample must hold while the read stage waits
  `BTS_ASSERT_NEXT(a_read_data_held, v3_r && !err3_r && !blend_rdy, $stable(tex))
  // out-of-range results carry zero color
  `BTS_ASSERT_NOW(a_range_zero, out_valid && out_req.status == STATUS_RANGE,
    out_req.sample_red == '0 && out_req.sample_green == '0 && out_req.sample_blue == '0)

endmodule
